@@ rtl/core/sgb_pkg.sv @@
// Shared constants, register indexes and types for the scaled glyph row blitter.
package sgb_pkg;

  // Default limits handed to the top level parameters
  localparam int SGB_MAX_SCALE_SHIFT = 3;
  localparam int SGB_MAX_CANVAS_DIM  = 2048;
  localparam int SGB_MAX_GLYPH_ROWS  = 32;

  localparam int BitsPerByte = 8;
  localparam int MaskW       = BitsPerByte << 3;  // eight font bits at the largest scale
  localparam int CntW        = 3;                 // row counter for up to eight rows
  localparam int PosW        = 14;                // signed working width for positions

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] REG_CANVAS_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CANVAS_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GLYPH_WIDTH   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SCALE_SHIFT   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FG_COLOR      = 3'd4;

  localparam logic [11:0] CANVAS_WIDTH_RST  = 12'd640;
  localparam logic [11:0] CANVAS_HEIGHT_RST = 12'd480;
  localparam logic [5:0]  GLYPH_WIDTH_RST   = 6'd8;
  localparam logic [1:0]  SCALE_SHIFT_RST   = 2'd0;
  localparam logic [23:0] FG_COLOR_RST      = 24'hFFFFFF;

  // Effective configuration after clamping and saturation
  typedef struct packed {
    logic [11:0] canvas_w;
    logic [11:0] canvas_h;
    logic [5:0]  glyph_w;
    logic [1:0]  scale;
    logic        row_ok;     // glyph row below the row limit
  } sgb_cfg_t;

  // Per-request data handed to the row sequencer
  typedef struct packed {
    logic signed [PosW-1:0] start_x;
    logic signed [PosW-1:0] base_y;
    logic [MaskW-1:0]       mask;
    logic [CntW-1:0]        last_cnt;
  } sgb_item_t;

endpackage

@@ rtl/core/sgb_expand.sv @@
// Horizontal expansion and clipping of one font byte into a row write mask.
module sgb_expand (
  input  sgb_pkg::sgb_cfg_t  cfg_i,
  input  logic signed [11:0] origin_x_i,
  input  logic signed [11:0] origin_y_i,
  input  logic [4:0]         glyph_row_i,
  input  logic [1:0]         byte_column_i,
  input  logic [7:0]         font_byte_i,
  output sgb_pkg::sgb_item_t item_o
);
  import sgb_pkg::*;

  logic signed [PosW-1:0] start_x;
  logic signed [PosW:0]   lo_bound;
  logic signed [PosW:0]   hi_bound;
  logic [BitsPerByte-1:0] col_keep;
  logic [MaskW-1:0]       mask;

  assign start_x = PosW'(origin_x_i) + (PosW'({byte_column_i, 3'b000}) << cfg_i.scale);

  // Pixel k is on canvas when lo_bound <= k < hi_bound
  assign lo_bound = -(PosW+1)'(start_x);
  assign hi_bound = $signed({3'b000, cfg_i.canvas_w}) - (PosW+1)'(start_x);

  always_comb begin
    for (int dx = 0; dx < BitsPerByte; dx++) begin
      col_keep[dx] = font_byte_i[BitsPerByte-1-dx] &&
                     ({1'b0, byte_column_i, 3'b000} + 6'(dx) < cfg_i.glyph_w);
    end
  end

  always_comb begin
    logic [5:0]           k_u;
    logic [5:0]           dx;
    logic signed [PosW:0] k_s;
    for (int k = 0; k < MaskW; k++) begin
      k_u = 6'(k);
      k_s = (PosW+1)'(k);
      dx  = k_u >> cfg_i.scale;
      mask[k] = cfg_i.row_ok && (dx < 6'(BitsPerByte)) && col_keep[dx[2:0]] &&
                (k_s >= lo_bound) && (k_s < hi_bound);
    end
  end

  assign item_o.start_x  = start_x;
  assign item_o.base_y   = PosW'(origin_y_i) + (PosW'(glyph_row_i) << cfg_i.scale);
  assign item_o.mask     = mask;
  assign item_o.last_cnt = CntW'((4'd1 << cfg_i.scale) - 4'd1);

endmodule

@@ rtl/core/sgb_row_seq.sv @@
// Row sequencer: steps through the destination rows and registers one result per cycle.
module sgb_row_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sgb_pkg::sgb_cfg_t  cfg_i,
  input  logic [23:0]        color_i,
  input  logic               load_i,
  input  sgb_pkg::sgb_item_t item_i,
  output logic               free_o,
  output logic               result_valid_o,
  output logic signed [12:0] row_y_o,
  output logic signed [12:0] row_start_x_o,
  output logic [21:0]        row_address_o,
  output logic [63:0]        write_mask_o,
  output logic [23:0]        pixel_color_o,
  output logic               row_visible_o,
  output logic               last_row_o
);
  import sgb_pkg::*;

  logic                   act_q, act_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  sgb_item_t              item_q;
  logic                   at_last;
  logic signed [PosW-1:0] ry;
  logic                   vis;
  logic [23:0]            prod;

  logic                   valid_q;
  logic signed [12:0]     row_y_q;
  logic signed [12:0]     start_x_q;
  logic [21:0]            addr_q;
  logic [MaskW-1:0]       mask_q;
  logic [23:0]            color_q;
  logic                   vis_q;
  logic                   last_q;

  assign at_last = (cnt_q == item_q.last_cnt);
  assign free_o  = !act_q || at_last;

  assign ry   = item_q.base_y + PosW'(cnt_q);
  assign vis  = (ry >= 0) && (ry < $signed({2'b00, cfg_i.canvas_h}));
  assign prod = ry[11:0] * cfg_i.canvas_w;

  always_comb begin
    act_d = act_q;
    cnt_d = cnt_q;
    if (load_i && free_o) begin
      act_d = 1'b1;
      cnt_d = '0;
    end else if (act_q) begin
      if (at_last) begin
        act_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      act_q   <= act_d;
      cnt_q   <= cnt_d;
      valid_q <= act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      item_q <= item_i;
    end
    if (act_q) begin
      row_y_q   <= ry[12:0];
      start_x_q <= item_q.start_x[12:0];
      addr_q    <= vis ? prod[21:0] : '0;
      mask_q    <= vis ? item_q.mask : '0;
      color_q   <= color_i;
      vis_q     <= vis;
      last_q    <= at_last;
    end
  end

  assign result_valid_o = valid_q;
  assign row_y_o        = row_y_q;
  assign row_start_x_o  = start_x_q;
  assign row_address_o  = addr_q;
  assign write_mask_o   = mask_q;
  assign pixel_color_o  = color_q;
  assign row_visible_o  = vis_q;
  assign last_row_o     = last_q;

`ifndef SYNTH
  a_hidden_row_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !vis_q |-> (mask_q == '0) && (addr_q == '0))
    else $error("off-canvas row carries a mask or an address");

  a_rows_continue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !last_q |=> valid_q)
    else $error("row sequence broken before its last row");

  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !last_q |=> row_y_q == $past(row_y_q) + 13'sd1)
    else $error("destination rows do not advance by one");
`endif

endmodule

@@ rtl/core/scaled_glyph_row_blitter.sv @@
// Flow: with the row sequencer idle, an accepted request passes the input register and the
// sequencer's item register before its first row strobes from the result register; rows
// then follow one per cycle, 2^scale_shift rows per request. The row sequencer takes
// the next request at the edge that registers the last row of the one before; one
// request waits in the input register meanwhile and busy_o holds off the next.
// Reset: rst_ni clears all control state and restores the register defaults; no result stall.
module scaled_glyph_row_blitter #(
  parameter int MAX_SCALE_SHIFT = sgb_pkg::SGB_MAX_SCALE_SHIFT,
  parameter int MAX_CANVAS_DIM  = sgb_pkg::SGB_MAX_CANVAS_DIM,
  parameter int MAX_GLYPH_ROWS  = sgb_pkg::SGB_MAX_GLYPH_ROWS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sgb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sgb_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [11:0]            origin_x_i,
  input  logic signed [11:0]            origin_y_i,
  input  logic [4:0]                    glyph_row_i,
  input  logic [1:0]                    byte_column_i,
  input  logic [7:0]                    font_byte_i,
  output logic                          result_valid_o,
  output logic signed [12:0]            row_y_o,
  output logic signed [12:0]            row_start_x_o,
  output logic [21:0]                   row_address_o,
  output logic [63:0]                   write_mask_o,
  output logic [23:0]                   pixel_color_o,
  output logic                          row_visible_o,
  output logic                          last_row_o
);
  import sgb_pkg::*;

  logic [11:0] canvas_w_q;
  logic [11:0] canvas_h_q;
  logic [5:0]  glyph_w_q;
  logic [1:0]  scale_q;
  logic [23:0] fg_color_q;

  logic               in_valid_q, in_valid_d;
  logic signed [11:0] ox_q;
  logic signed [11:0] oy_q;
  logic [4:0]         grow_q;
  logic [1:0]         bcol_q;
  logic [7:0]         fbyte_q;

  logic      accept;
  logic      seq_free;
  logic      hand_over;
  sgb_cfg_t  cfg_eff;
  sgb_item_t item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w_q <= CANVAS_WIDTH_RST;
      canvas_h_q <= CANVAS_HEIGHT_RST;
      glyph_w_q  <= GLYPH_WIDTH_RST;
      scale_q    <= SCALE_SHIFT_RST;
      fg_color_q <= FG_COLOR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CANVAS_WIDTH:  canvas_w_q <= cfg_data_i[11:0];
        REG_CANVAS_HEIGHT: canvas_h_q <= cfg_data_i[11:0];
        REG_GLYPH_WIDTH:   glyph_w_q  <= cfg_data_i[5:0];
        REG_SCALE_SHIFT:   scale_q    <= cfg_data_i[1:0];
        REG_FG_COLOR:      fg_color_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Clamp canvas dimensions, saturate the scale and flag out-of-range glyph rows
  always_comb begin
    cfg_eff.canvas_w = (int'(canvas_w_q) > MAX_CANVAS_DIM) ? 12'(MAX_CANVAS_DIM) : canvas_w_q;
    cfg_eff.canvas_h = (int'(canvas_h_q) > MAX_CANVAS_DIM) ? 12'(MAX_CANVAS_DIM) : canvas_h_q;
    cfg_eff.glyph_w  = glyph_w_q;
    cfg_eff.scale    = (int'(scale_q) > MAX_SCALE_SHIFT) ? 2'(MAX_SCALE_SHIFT) : scale_q;
    cfg_eff.row_ok   = int'(grow_q) < MAX_GLYPH_ROWS;
  end

  // Hold the request until the sequencer can take it
  assign hand_over = in_valid_q && seq_free;
  assign busy_o    = in_valid_q && !seq_free;
  assign accept    = start_i && !busy_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (hand_over) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ox_q    <= origin_x_i;
      oy_q    <= origin_y_i;
      grow_q  <= glyph_row_i;
      bcol_q  <= byte_column_i;
      fbyte_q <= font_byte_i;
    end
  end

  sgb_expand u_expand (
    .cfg_i         (cfg_eff),
    .origin_x_i    (ox_q),
    .origin_y_i    (oy_q),
    .glyph_row_i   (grow_q),
    .byte_column_i (bcol_q),
    .font_byte_i   (fbyte_q),
    .item_o        (item)
  );

  sgb_row_seq u_row_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_eff),
    .color_i        (fg_color_q),
    .load_i         (in_valid_q),
    .item_i         (item),
    .free_o         (seq_free),
    .result_valid_o (result_valid_o),
    .row_y_o        (row_y_o),
    .row_start_x_o  (row_start_x_o),
    .row_address_o  (row_address_o),
    .write_mask_o   (write_mask_o),
    .pixel_color_o  (pixel_color_o),
    .row_visible_o  (row_visible_o),
    .last_row_o     (last_row_o)
  );

`ifndef SYNTH
  a_busy_means_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> result_valid_o)
    else $error("busy without a row in flight");

  a_hand_over_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hand_over |=> ##1 result_valid_o)
    else $error("request handed over but no row followed");

  a_accept_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_valid_q)
    else $error("accepted request not held in the input register");
`endif

endmodule
